// File: src/cbsu_pkg.sv
// Shared types, opcode field codes and constants for the CB-prefix bit/shift unit.
// No dependencies; imported by the top level, cbsu_exec and the bench.
`default_nettype none

package cbsu_pkg;

    localparam int RegCount = 7;
    localparam int RegIdxW  = 3;

    // Register file entries: B, C, D, E, H, L, A
    localparam logic [RegIdxW-1:0] REG_H = 3'd4;
    localparam logic [RegIdxW-1:0] REG_L = 3'd5;
    localparam logic [RegIdxW-1:0] REG_A = 3'd6;

    // Operand select codes (opcode bits 2..0)
    localparam logic [2:0] OPERAND_HL = 3'd6;
    localparam logic [2:0] OPERAND_A  = 3'd7;

    // Group codes (opcode bits 7..6)
    localparam logic [1:0] GROUP_SHIFT = 2'd0;
    localparam logic [1:0] GROUP_BIT   = 2'd1;
    localparam logic [1:0] GROUP_RES   = 2'd2;
    localparam logic [1:0] GROUP_SET   = 2'd3;

    // Rotate/shift kinds (opcode bits 5..3 in the shift group)
    localparam logic [2:0] SH_RLC  = 3'd0;
    localparam logic [2:0] SH_RRC  = 3'd1;
    localparam logic [2:0] SH_RL   = 3'd2;
    localparam logic [2:0] SH_RR   = 3'd3;
    localparam logic [2:0] SH_SLA  = 3'd4;
    localparam logic [2:0] SH_SRA  = 3'd5;
    localparam logic [2:0] SH_SWAP = 3'd6;
    localparam logic [2:0] SH_SRL  = 3'd7;

    // Flag nibble bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [4:0] CYCLES_REG    = 5'd8;
    localparam logic [4:0] CYCLES_BIT_HL = 5'd12;
    localparam logic [4:0] CYCLES_HL     = 5'd16;

    typedef logic [RegCount-1:0][7:0] regfile_t;

    typedef struct packed {
        logic [7:0]  result_value;
        logic [3:0]  flags_out;
        logic        mem_write;
        logic [15:0] mem_address;
        logic [7:0]  mem_write_data;
        logic [4:0]  cycle_count;
        logic [15:0] next_pc;
    } result_t;

    typedef struct packed {
        logic               reg_we;
        logic [RegIdxW-1:0] reg_idx;
        logic [7:0]         reg_value;
    } reg_update_t;

endpackage

`default_nettype wire

// File: src/cbsu_in_if.sv
// Input channel: one instruction word (opcode plus byte at HL) with valid/ready.
// Depends on nothing.
`default_nettype none

interface cbsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] opcode;
    logic [7:0] mem_data;

    modport source (output valid, output opcode, output mem_data, input ready);
    modport sink   (input valid, input opcode, input mem_data, output ready);
endinterface

`default_nettype wire

// File: src/cbsu_out_if.sv
// Output channel: one result word per instruction with valid/ready.
// Depends on nothing.
`default_nettype none

interface cbsu_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  result_value;
    logic [3:0]  flags_out;
    logic        mem_write;
    logic [15:0] mem_address;
    logic [7:0]  mem_write_data;
    logic [4:0]  cycle_count;
    logic [15:0] next_pc;

    modport source (output valid, output result_value, output flags_out, output mem_write,
                    output mem_address, output mem_write_data, output cycle_count,
                    output next_pc, input ready);
    modport sink   (input valid, input result_value, input flags_out, input mem_write,
                    input mem_address, input mem_write_data, input cycle_count,
                    input next_pc, output ready);
endinterface

`default_nettype wire

// File: src/cb_prefix_bit_shift_unit_top.sv
// Top level of the CB-prefix bit/shift unit: input register, execute logic, result register.
// Depends on cbsu_pkg, cbsu_in_if, cbsu_out_if and cbsu_exec.
`default_nettype none

// Executes the second byte of a CB-prefixed SM83 instruction (rotates, shifts,
// SWAP, BIT, RES, SET) against an internal register file B, C, D, E, H, L, A,
// a Z/N/H/C flag nibble and a program counter, all cleared by reset. Each
// input word carries the opcode and the byte currently at HL; the result word
// gives the new operand value, flags, an optional write back to HL, the cycle
// count of the instruction (8, 12 or 16) and the next PC. Throughput is one
// word per clock while the receiver takes results: an accepted word waits in
// the input register, is executed in a single combinational pass, and lands
// in the result register once that register is empty or being taken, which
// makes the result word valid on the channel. The register file, flags and
// PC update at the same edge the result is captured, so the next word
// already sees them. Input ready drops only when both registers hold a
// word and the result is not being taken.

module cb_prefix_bit_shift_unit_top
    import cbsu_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    cbsu_in_if.sink    item_in,
    cbsu_out_if.source item_out
);

    // input stage
    logic        in_valid_reg;
    logic [7:0]  opcode_reg;
    logic [7:0]  mem_data_reg;

    // architectural state
    regfile_t    regs_reg;
    logic [3:0]  flags_reg;
    logic [15:0] pc_reg;

    // result stage
    logic        out_valid_reg;
    result_t     out_reg;

    result_t     exec_result;
    reg_update_t exec_reg_upd;
    logic [3:0]  exec_flags;

    logic        out_advance;
    logic        exec_fire;

    assign out_advance   = !out_valid_reg || item_out.ready;
    assign exec_fire     = in_valid_reg && out_advance;
    assign item_in.ready = !in_valid_reg || out_advance;

    cbsu_exec u_exec (
        .opcode     (opcode_reg),
        .mem_data   (mem_data_reg),
        .regs       (regs_reg),
        .flags      (flags_reg),
        .pc         (pc_reg),
        .result     (exec_result),
        .reg_upd    (exec_reg_upd),
        .flags_next (exec_flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            regs_reg      <= '0;
            flags_reg     <= 4'h0;
            pc_reg        <= 16'h0000;
        end
        else
        begin
            if (item_in.ready)
                in_valid_reg <= item_in.valid;
            if (out_advance)
                out_valid_reg <= in_valid_reg;
            if (exec_fire)
            begin
                flags_reg <= exec_flags;
                pc_reg    <= exec_result.next_pc;
                if (exec_reg_upd.reg_we)
                    regs_reg[exec_reg_upd.reg_idx] <= exec_reg_upd.reg_value;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (item_in.ready && item_in.valid)
        begin
            opcode_reg   <= item_in.opcode;
            mem_data_reg <= item_in.mem_data;
        end
        if (exec_fire)
            out_reg <= exec_result;
    end

    assign item_out.valid          = out_valid_reg;
    assign item_out.result_value   = out_reg.result_value;
    assign item_out.flags_out      = out_reg.flags_out;
    assign item_out.mem_write      = out_reg.mem_write;
    assign item_out.mem_address    = out_reg.mem_address;
    assign item_out.mem_write_data = out_reg.mem_write_data;
    assign item_out.cycle_count    = out_reg.cycle_count;
    assign item_out.next_pc        = out_reg.next_pc;

endmodule

`default_nettype wire

// File: src/cbsu_exec.sv
// Combinational execute logic for one CB-prefixed opcode.
// Depends on cbsu_pkg.
`default_nettype none

module cbsu_exec
    import cbsu_pkg::*;
(
    input  wire logic [7:0]  opcode,
    input  wire logic [7:0]  mem_data,
    input  wire regfile_t    regs,
    input  wire logic [3:0]  flags,
    input  wire logic [15:0] pc,
    output result_t          result,
    output reg_update_t      reg_upd,
    output logic [3:0]       flags_next
);

    logic [2:0]         sel;
    logic [1:0]         grp;
    logic [2:0]         fld;
    logic               is_mem;
    logic [RegIdxW-1:0] ridx;
    logic [7:0]         operand;
    logic [7:0]         bit_mask;
    logic [7:0]         sh_value;
    logic               sh_carry;
    logic [7:0]         res;
    logic               writes;
    logic               cin;

    assign sel      = opcode[2:0];
    assign grp      = opcode[7:6];
    assign fld      = opcode[5:3];
    assign is_mem   = (sel == OPERAND_HL);
    assign ridx     = (sel == OPERAND_A) ? REG_A : sel;
    assign operand  = is_mem ? mem_data : regs[ridx];
    assign bit_mask = 8'b1 << fld;
    assign cin      = flags[FLAG_C];

    always_comb
    begin
        unique case (fld)
            SH_RLC:  begin sh_carry = operand[7]; sh_value = {operand[6:0], operand[7]}; end
            SH_RRC:  begin sh_carry = operand[0]; sh_value = {operand[0], operand[7:1]}; end
            SH_RL:   begin sh_carry = operand[7]; sh_value = {operand[6:0], cin}; end
            SH_RR:   begin sh_carry = operand[0]; sh_value = {cin, operand[7:1]}; end
            SH_SLA:  begin sh_carry = operand[7]; sh_value = {operand[6:0], 1'b0}; end
            SH_SRA:  begin sh_carry = operand[0]; sh_value = {operand[7], operand[7:1]}; end
            SH_SWAP: begin sh_carry = 1'b0;       sh_value = {operand[3:0], operand[7:4]}; end
            SH_SRL:  begin sh_carry = operand[0]; sh_value = {1'b0, operand[7:1]}; end
            default: begin sh_carry = 1'b0;       sh_value = operand; end
        endcase
    end

    always_comb
    begin
        res        = operand;
        writes     = 1'b1;
        flags_next = flags;
        unique case (grp)
            GROUP_SHIFT:
            begin
                res        = sh_value;
                flags_next = {(sh_value == 8'h00), 1'b0, 1'b0, sh_carry};
            end
            GROUP_BIT:
            begin
                writes     = 1'b0;
                flags_next = {~|(operand & bit_mask), 1'b0, 1'b1, flags[FLAG_C]};
            end
            GROUP_RES: res = operand & ~bit_mask;
            GROUP_SET: res = operand | bit_mask;
            default:   res = operand;
        endcase
    end

    always_comb
    begin
        result.result_value   = res;
        result.flags_out      = flags_next;
        result.mem_write      = is_mem && writes;
        result.mem_address    = {regs[REG_H], regs[REG_L]};
        result.mem_write_data = (is_mem && writes) ? res : 8'h00;
        result.cycle_count    = !is_mem ? CYCLES_REG : (writes ? CYCLES_HL : CYCLES_BIT_HL);
        result.next_pc        = pc + 16'd1;

        reg_upd.reg_we    = !is_mem && writes;
        reg_upd.reg_idx   = ridx;
        reg_upd.reg_value = res;
    end

endmodule

`default_nettype wire

// File: sim/cb_prefix_bit_shift_unit_top_tb.sv
// Self-checking bench for cb_prefix_bit_shift_unit_top: CB-prefix rotates, shifts, BIT/RES/SET.
// Depends on cbsu_pkg, cbsu_in_if, cbsu_out_if and the RTL top; reads no files.
// An in-bench predictor tracks the register file, flags and PC and checks every result word.

module cb_prefix_bit_shift_unit_top_tb;
    import cbsu_pkg::*;

    // Register operand codes that the package does not name (bits 2..0 of the opcode)
    localparam logic [2:0] OPD_B = 3'd0;
    localparam logic [2:0] OPD_C = 3'd1;
    localparam logic [2:0] OPD_H = 3'd4;
    localparam logic [2:0] OPD_L = 3'd5;

    localparam int MaxPrinted = 40;

    // Receiver stall styles; each one runs for a random stretch of cycles
    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_BLOCK} rx_style_e;

    logic clk = 1'b0;
    logic rst_n;

    cbsu_in_if  item_in ();
    cbsu_out_if item_out ();

    cb_prefix_bit_shift_unit_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_in  (item_in),
        .item_out (item_out)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow CPU state: B, C, D, E, H, L, A at entries 0..6, Z/N/H/C nibble, PC
    logic [7:0]  cpu_regs [RegCount];
    logic [3:0]  cpu_flags;
    logic [15:0] cpu_pc;

    result_t results_due [$];
    int      mismatch_count = 0;

    // Sender / receiver shaping knobs
    int        burst_left = 0;
    bit        full_rate  = 1'b0;   // no sender gaps, receiver always ready
    rx_style_e rx_style   = RX_STEADY;
    int        rx_left    = 0;

    // Output word as seen on the channel, packed in result_t field order
    result_t out_word;
    assign out_word = '{item_out.result_value, item_out.flags_out, item_out.mem_write,
                        item_out.mem_address, item_out.mem_write_data, item_out.cycle_count,
                        item_out.next_pc};

    // Executes one CB opcode on the shadow state and returns the result word it yields.
    function automatic result_t execute_cb(input logic [7:0] op, input logic [7:0] md);
        logic [2:0] opd;
        logic [2:0] fld;
        logic [1:0] grp;
        logic [2:0] ridx;
        logic       is_mem;
        logic       writes;
        logic       cout;
        logic [7:0] v;
        logic [7:0] r;
        logic [3:0] fl;
        result_t    res;
        opd    = op[2:0];
        fld    = op[5:3];
        grp    = op[7:6];
        is_mem = (opd == OPERAND_HL);
        ridx   = (opd == OPERAND_A) ? REG_A : opd;
        v      = is_mem ? md : cpu_regs[ridx];
        r      = v;
        fl     = cpu_flags;
        writes = 1'b1;
        case (grp)
            GROUP_SHIFT:
            begin
                case (fld)
                    SH_RLC:  begin cout = v[7]; r = {v[6:0], v[7]};           end
                    SH_RRC:  begin cout = v[0]; r = {v[0], v[7:1]};           end
                    SH_RL:   begin cout = v[7]; r = {v[6:0], fl[FLAG_C]};     end
                    SH_RR:   begin cout = v[0]; r = {fl[FLAG_C], v[7:1]};     end
                    SH_SLA:  begin cout = v[7]; r = {v[6:0], 1'b0};           end
                    SH_SRA:  begin cout = v[0]; r = {v[7], v[7:1]};           end
                    SH_SWAP: begin cout = 1'b0; r = {v[3:0], v[7:4]};         end
                    default: begin cout = v[0]; r = {1'b0, v[7:1]};           end
                endcase
                fl         = '0;
                fl[FLAG_Z] = (r == 8'h00);
                fl[FLAG_C] = cout;
            end
            GROUP_BIT:
            begin
                // carry kept, N cleared, H set, Z = tested bit inverted
                writes     = 1'b0;
                fl[FLAG_Z] = ~v[fld];
                fl[FLAG_N] = 1'b0;
                fl[FLAG_H] = 1'b1;
            end
            GROUP_RES: r[fld] = 1'b0;
            default:   r[fld] = 1'b1;
        endcase
        res.result_value   = r;
        res.flags_out      = fl;
        res.mem_write      = is_mem && writes;
        res.mem_address    = {cpu_regs[REG_H], cpu_regs[REG_L]};
        res.mem_write_data = (is_mem && writes) ? r : 8'h00;
        res.cycle_count    = is_mem ? (writes ? CYCLES_HL : CYCLES_BIT_HL) : CYCLES_REG;
        res.next_pc        = cpu_pc + 16'd1;
        if (!is_mem && writes)
            cpu_regs[ridx] = r;
        cpu_flags = fl;
        cpu_pc    = res.next_pc;
        return res;
    endfunction

    function automatic logic [7:0] cb_op(input logic [1:0] grp, input logic [2:0] fld,
                                         input logic [2:0] opd);
        return {grp, fld, opd};
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MaxPrinted)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task automatic check_word(input result_t got);
        result_t want;
        if (results_due.size() == 0)
        begin
            report_mismatch("result word with no prediction pending");
            return;
        end
        want = results_due.pop_front();
        compare_field("result_value",   got.result_value,   want.result_value);
        compare_field("flags_out",      got.flags_out,      want.flags_out);
        compare_field("mem_write",      got.mem_write,      want.mem_write);
        compare_field("mem_address",    got.mem_address,    want.mem_address);
        compare_field("mem_write_data", got.mem_write_data, want.mem_write_data);
        compare_field("cycle_count",    got.cycle_count,    want.cycle_count);
        compare_field("next_pc",        got.next_pc,        want.next_pc);
    endtask

    // Prediction and checking share one process, so ordering at an edge never matters:
    // the input word is executed first, then any output word is compared.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_in.valid && item_in.ready)
                results_due.push_back(execute_cb(item_in.opcode, item_in.mem_data));
            if (item_out.valid && item_out.ready)
                check_word(out_word);
        end
    end

    // Receiver backpressure: a random style held for a random stretch.
    always @(posedge clk)
    begin
        if (full_rate)
            item_out.ready <= 1'b1;
        else
        begin
            if (rx_left == 0)
            begin
                rx_style = rx_style_e'($urandom_range(0, 3));
                rx_left  = $urandom_range(4, 40);
            end
            rx_left--;
            case (rx_style)
                RX_STEADY: item_out.ready <= 1'b1;
                RX_COIN:   item_out.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: item_out.ready <= ($urandom_range(0, 3) == 0);
                default:   item_out.ready <= (rx_left < 4);   // long stall, short release
            endcase
        end
    end

    // Sends one word; the sender runs in bursts with random gaps in between.
    // Valid stays high across a burst, so it gets one assignment per edge.
    task automatic send_word(input logic [7:0] op, input logic [7:0] md);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (full_rate || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                item_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_in.valid    <= 1'b1;
        item_in.opcode   <= op;
        item_in.mem_data <= md;
        do
            @(posedge clk);
        while (!item_in.ready);
    endtask

    // Drops valid and holds off until every predicted word has come back.
    task automatic wait_results_drained();
        item_in.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (results_due.size() != 0);
    endtask

    // Rotates and shifts on a register and on (HL); registers start at zero,
    // so a few SETs seed A and the HL address first.
    task automatic test_rotate_shift();
        send_word(cb_op(GROUP_BIT, 3'd0, OPD_B), 8'hA5);      // all-zero state, mem ignored
        send_word(cb_op(GROUP_SET, 3'd7, OPD_H), 8'hFF);
        send_word(cb_op(GROUP_SET, 3'd0, OPD_L), 8'h00);      // HL = 0x8001
        send_word(cb_op(GROUP_SET, 3'd7, OPERAND_A), 8'h5A);  // A = 0x80
        send_word(cb_op(GROUP_SHIFT, SH_RLC, OPERAND_A), 8'hFF);
        send_word(cb_op(GROUP_SHIFT, SH_RL, OPERAND_A), 8'h00);   // carry in set
        send_word(cb_op(GROUP_SHIFT, SH_RR, OPERAND_A), 8'hFF);   // carry in clear
        send_word(cb_op(GROUP_SHIFT, SH_RR, OPERAND_A), 8'h00);   // carry in set
        send_word(cb_op(GROUP_SHIFT, SH_SRA, OPERAND_A), 8'hFF);  // sign bit kept
        send_word(cb_op(GROUP_SHIFT, SH_SLA, OPERAND_A), 8'h00);
        send_word(cb_op(GROUP_SHIFT, SH_RRC, OPERAND_A), 8'hFF);
        send_word(cb_op(GROUP_SHIFT, SH_SRL, OPERAND_A), 8'h00);
        send_word(cb_op(GROUP_SHIFT, SH_SWAP, OPERAND_A), 8'hFF);
        send_word(cb_op(GROUP_SHIFT, SH_SRL, OPD_C), 8'hFF);      // zero result
        send_word(cb_op(GROUP_SHIFT, SH_RLC, OPERAND_HL), 8'hFF);
        send_word(cb_op(GROUP_SHIFT, SH_SRL, OPERAND_HL), 8'h01); // zero result, carry out
        send_word(cb_op(GROUP_SHIFT, SH_SWAP, OPERAND_HL), 8'hF0);
        send_word(cb_op(GROUP_SHIFT, SH_SRA, OPERAND_HL), 8'h81);
    endtask

    // BIT keeps carry (set by the previous shift), BIT on (HL) writes nothing.
    task automatic test_bit_res_set();
        send_word(cb_op(GROUP_BIT, 3'd7, OPERAND_HL), 8'h80);
        send_word(cb_op(GROUP_BIT, 3'd0, OPERAND_HL), 8'h00);
        send_word(cb_op(GROUP_RES, 3'd0, OPERAND_HL), 8'hFF);
        send_word(cb_op(GROUP_SET, 3'd7, OPERAND_HL), 8'h00);
        send_word(cb_op(GROUP_RES, 3'd7, OPD_H), 8'h00);
        send_word(cb_op(GROUP_BIT, 3'd7, OPERAND_A), 8'hFF);
    endtask

    // Fully random opcodes and bytes, with (HL) forms weighted up.
    task automatic test_random_mix(input int count);
        logic [7:0] op;
        repeat (count)
        begin
            op = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                op[2:0] = OPERAND_HL;
            send_word(op, 8'($urandom_range(0, 255)));
        end
    endtask

    // Pause mid-run until the pipe is empty, then resume.
    task automatic test_drain_pause();
        wait_results_drained();
        test_random_mix(30);
    endtask

    // Runs flat out: no sender gaps and a receiver that never stalls, so
    // words move through back to back.
    task automatic test_full_rate(input int count);
        wait_results_drained();
        full_rate = 1'b1;
        test_random_mix(count);
        wait_results_drained();
        full_rate = 1'b0;
    endtask

    initial
    begin
        foreach (cpu_regs[i])
            cpu_regs[i] = 8'h00;
        cpu_flags        = 4'h0;
        cpu_pc           = 16'h0000;
        rst_n            = 1'b0;
        item_in.valid    = 1'b0;
        item_in.opcode   = 8'h00;
        item_in.mem_data = 8'h00;
        item_out.ready   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_rotate_shift();
        test_bit_res_set();
        test_random_mix(470);
        test_drain_pause();
        test_full_rate(100);
        test_random_mix(326);

        // Flush: nothing pending, then a few cycles to catch stray words.
        wait_results_drained();
        repeat (16) @(posedge clk);
        if (results_due.size() != 0)
            report_mismatch($sformatf("%0d predicted words never arrived", results_due.size()));
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hang guard: well over the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
src/cbsu_pkg.sv
src/cbsu_in_if.sv
src/cbsu_out_if.sv
src/cbsu_exec.sv
src/cb_prefix_bit_shift_unit_top.sv
sim/cb_prefix_bit_shift_unit_top_tb.sv
